/* hdl/seven_segment_mux_driver_core_defines.svh */
// Assertion macros shared by the seven-segment mux driver RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEVEN_SEGMENT_MUX_DRIVER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSMD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ssmd check failed");
// next-cycle implication
`define SSMD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ssmd check failed");
`else
`define SSMD_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define SSMD_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* hdl/ssmd_pkg.sv */
// Package for the seven-segment mux driver: types, codes, font table and
// segment permutations. No dependencies.
`timescale 1ns / 1ps

package ssmd_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int NUM_ENABLE     = 4;
    localparam int SEG_W          = 8;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    // reset values of the register file
    localparam logic [SEG_W-1:0] BLANK_RESET = 8'hFF;
    localparam logic [SEG_W-1:0] EN0_RESET   = 8'h01;
    localparam logic [SEG_W-1:0] EN1_RESET   = 8'h02;
    localparam logic [SEG_W-1:0] EN2_RESET   = 8'h04;
    localparam logic [SEG_W-1:0] EN3_RESET   = 8'h08;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_BLANK = 3'd0;
    localparam logic [2:0] REG_EN0   = 3'd1;
    localparam logic [2:0] REG_EN1   = 3'd2;
    localparam logic [2:0] REG_EN2   = 3'd3;
    localparam logic [2:0] REG_EN3   = 3'd4;

    // segment masks and notable glyphs
    localparam logic [SEG_W-1:0] MASK_GDP  = 8'b11000000;
    localparam logic [SEG_W-1:0] MASK_ABC  = 8'b00000111;
    localparam logic [SEG_W-1:0] MASK_DEF  = 8'b00111000;
    localparam logic [SEG_W-1:0] GLYPH_UND = 8'b00001000;
    localparam logic [SEG_W-1:0] GLYPH_0   = 8'b00111111;
    localparam logic [SEG_W-1:0] GLYPH_A   = 8'b01110111;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DOTS  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic tick;
        logic write_char;
        logic clear_dots;
        logic clear_all;
    } cmd_t;

    typedef struct packed {
        logic [SEG_W-1:0]                 blank;
        logic [NUM_ENABLE-1:0][SEG_W-1:0] enable;
    } cfg_t;

    // bit 0 = a .. bit 6 = g, bit 7 = dot
    function automatic logic [SEG_W-1:0] font(input logic [7:0] c);
        logic [SEG_W-1:0] s;
        case (c)
            "0", "O":                s = GLYPH_0;
            "1":                     s = 8'h06;
            "2":                     s = 8'h5B;
            "3":                     s = 8'h4F;
            "4":                     s = 8'h66;
            "5", "s", "S", "z", "Z": s = 8'h6D;
            "6":                     s = 8'h7D;
            "7":                     s = 8'h07;
            "8":                     s = 8'h7F;
            "9", "g":                s = 8'h6F;
            "a", "A":                s = GLYPH_A;
            "b", "B":                s = 8'h7C;
            "c":                     s = 8'h58;
            "C":                     s = 8'h39;
            "d", "D":                s = 8'h5E;
            "e":                     s = 8'h7B;
            "E":                     s = 8'h79;
            "f", "F":                s = 8'h71;
            "G":                     s = 8'h3D;
            "h":                     s = 8'h74;
            "H", "x", "X":           s = 8'h76;
            "i":                     s = 8'h10;
            "I", "l":                s = 8'h30;
            "j":                     s = 8'h1E;
            "J":                     s = 8'h1F;
            "k", "K":                s = 8'h70;
            "L":                     s = 8'h38;
            "m", "n":                s = 8'h54;
            "M", "N":                s = 8'h37;
            8'd164, 8'd165:          s = 8'h55;
            "o":                     s = 8'h5C;
            "p", "P":                s = 8'h73;
            "q":                     s = 8'hDC;
            "Q":                     s = 8'hBF;
            "r":                     s = 8'h50;
            "R", "T":                s = 8'h31;
            "t":                     s = 8'h78;
            "u", "v":                s = 8'h1C;
            "U", "V":                s = 8'h3E;
            "w":                     s = 8'h9C;
            "W":                     s = 8'hBE;
            "y", "Y":                s = 8'h6E;
            " ":                     s = 8'h00;
            "-":                     s = 8'h40;
            "!":                     s = 8'h82;
            ":", ".", ",":           s = 8'h80;
            default:                 s = GLYPH_UND;
        endcase
        return s;
    endfunction

    // display zero pin order
    function automatic logic [SEG_W-1:0] to_pin_order(input logic [SEG_W-1:0] s);
        return {s[3], s[4], s[2], s[6], s[7], s[1], s[5], s[0]};
    endfunction

    // display one: swap a-b-c with d-e-f
    function automatic logic [SEG_W-1:0] to_upside_down(input logic [SEG_W-1:0] s);
        return (s & MASK_GDP) | ((s & MASK_ABC) << 3) | ((s & MASK_DEF) >> 3);
    endfunction

endpackage

/* hdl/ssmd_cfg_regs.sv */
// APB register file of the seven-segment mux driver: blank pattern and
// per-digit enable masks. Depends on ssmd_pkg.
`timescale 1ns / 1ps

module ssmd_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssmd_pkg::APB_AW-1:0]  paddr,
    input  logic [ssmd_pkg::APB_DW-1:0]  pwdata,
    output logic [ssmd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output ssmd_pkg::cfg_t               cfg
);

    ssmd_pkg::cfg_t   cfg_reg;
    ssmd_pkg::cfg_t   cfg_next;
    logic [2:0]       reg_sel;
    logic             wr_en;
    logic [ssmd_pkg::SEG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                ssmd_pkg::REG_BLANK: cfg_next.blank     = pwdata[7:0];
                ssmd_pkg::REG_EN0:   cfg_next.enable[0] = pwdata[7:0];
                ssmd_pkg::REG_EN1:   cfg_next.enable[1] = pwdata[7:0];
                ssmd_pkg::REG_EN2:   cfg_next.enable[2] = pwdata[7:0];
                ssmd_pkg::REG_EN3:   cfg_next.enable[3] = pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank     <= ssmd_pkg::BLANK_RESET;
            cfg_reg.enable[0] <= ssmd_pkg::EN0_RESET;
            cfg_reg.enable[1] <= ssmd_pkg::EN1_RESET;
            cfg_reg.enable[2] <= ssmd_pkg::EN2_RESET;
            cfg_reg.enable[3] <= ssmd_pkg::EN3_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            ssmd_pkg::REG_BLANK: rd_val = cfg_reg.blank;
            ssmd_pkg::REG_EN0:   rd_val = cfg_reg.enable[0];
            ssmd_pkg::REG_EN1:   rd_val = cfg_reg.enable[1];
            ssmd_pkg::REG_EN2:   rd_val = cfg_reg.enable[2];
            ssmd_pkg::REG_EN3:   rd_val = cfg_reg.enable[3];
            default:             rd_val = '0;
        endcase
    end

    assign prdata = {{(ssmd_pkg::APB_DW - ssmd_pkg::SEG_W){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

/* hdl/ssmd_ctrl.sv */
// Controller of the seven-segment mux driver: input handshake, result slot
// state and command decode. Depends on ssmd_pkg and the defines header.
`timescale 1ns / 1ps
`include "seven_segment_mux_driver_core_defines.svh"

module ssmd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    output logic              out_valid,
    input  logic              out_ready,
    output ssmd_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_FULL  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // slot frees up in the same cycle it is taken
    assign in_ready = (state_reg == S_EMPTY) || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.tick       = accept && (op == ssmd_pkg::OP_TICK);
        cmd.write_char = accept && (op == ssmd_pkg::OP_WRITE);
        cmd.clear_dots = accept && (op == ssmd_pkg::OP_DOTS);
        cmd.clear_all  = accept && (op == ssmd_pkg::OP_CLEAR);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_EMPTY:
            begin
                if (cmd.tick)
                    state_next = S_FULL;
            end
            S_FULL:
            begin
                if (out_ready && !cmd.tick)
                    state_next = S_EMPTY;
            end
            default: state_next = S_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_EMPTY;
        else
            state_reg <= state_next;
    end

    assign out_valid = (state_reg == S_FULL);

    `SSMD_ASSERT_NEXT(a_tick_makes_result, clk, rst_n, cmd.tick, out_valid)
    `SSMD_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
    `SSMD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

/* hdl/ssmd_datapath.sv */
// Datapath of the seven-segment mux driver: digit stores, font encode,
// scan index and result registers. Depends on ssmd_pkg and the defines header.
`timescale 1ns / 1ps
`include "seven_segment_mux_driver_core_defines.svh"

module ssmd_datapath
#(
    parameter int DIGITS = ssmd_pkg::DIGITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssmd_pkg::cmd_t              cmd,
    input  ssmd_pkg::cfg_t              cfg,
    input  logic                        which_display,
    input  logic [1:0]                  position,
    input  logic [7:0]                  character,
    input  logic [7:0]                  dots_mask,
    output logic [1:0]                  digit_index,
    output logic [ssmd_pkg::SEG_W-1:0]  segments_first,
    output logic [ssmd_pkg::SEG_W-1:0]  segments_second,
    output logic [ssmd_pkg::SEG_W-1:0]  enable_lines
);

    localparam int IDX_W = $clog2(DIGITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

    logic [DIGITS-1:0][ssmd_pkg::SEG_W-1:0] first_store_reg;
    logic [DIGITS-1:0][ssmd_pkg::SEG_W-1:0] first_store_next;
    logic [DIGITS-1:0][ssmd_pkg::SEG_W-1:0] second_store_reg;
    logic [DIGITS-1:0][ssmd_pkg::SEG_W-1:0] second_store_next;
    logic [IDX_W-1:0]                       scan_index_reg;
    logic [IDX_W-1:0]                       scan_index_next;

    logic [1:0]                 digit_index_reg;
    logic [ssmd_pkg::SEG_W-1:0] seg_first_reg;
    logic [ssmd_pkg::SEG_W-1:0] seg_second_reg;
    logic [ssmd_pkg::SEG_W-1:0] enable_lines_reg;

    logic                       pos_ok;
    logic [IDX_W-1:0]           pos_idx;
    logic [ssmd_pkg::SEG_W-1:0] glyph;
    logic [ssmd_pkg::SEG_W-1:0] enc_first;
    logic [ssmd_pkg::SEG_W-1:0] enc_second;

    assign pos_ok     = ({1'b0, position} < 3'(DIGITS));
    assign pos_idx    = position[IDX_W-1:0];
    assign glyph      = ssmd_pkg::font(character);
    assign enc_first  = ~ssmd_pkg::to_pin_order(glyph);
    assign enc_second = ~ssmd_pkg::to_upside_down(glyph);

    always_comb
    begin
        first_store_next  = first_store_reg;
        second_store_next = second_store_reg;
        if (cmd.clear_all)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                first_store_next[i]  = cfg.blank;
                second_store_next[i] = cfg.blank;
            end
        end
        else if (cmd.write_char && pos_ok)
        begin
            if (!which_display)
                first_store_next[pos_idx] = enc_first;
            else
                second_store_next[pos_idx] = enc_second;
        end
        else if (cmd.clear_dots && pos_ok)
        begin
            if (!which_display)
                first_store_next[pos_idx] = first_store_reg[pos_idx] & ~dots_mask;
            else
                second_store_next[pos_idx] = second_store_reg[pos_idx] & ~dots_mask;
        end
    end

    always_comb
    begin
        scan_index_next = scan_index_reg;
        if (cmd.tick)
        begin
            if (scan_index_reg == LAST_IDX)
                scan_index_next = '0;
            else
                scan_index_next = scan_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                first_store_reg[i]  <= ssmd_pkg::BLANK_RESET;
                second_store_reg[i] <= ssmd_pkg::BLANK_RESET;
            end
            scan_index_reg <= '0;
        end
        else
        begin
            first_store_reg  <= first_store_next;
            second_store_reg <= second_store_next;
            scan_index_reg   <= scan_index_next;
        end
    end

    // result payload, loaded on tick only
    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            digit_index_reg  <= 2'(scan_index_reg);
            seg_first_reg    <= first_store_reg[scan_index_reg];
            seg_second_reg   <= second_store_reg[scan_index_reg];
            enable_lines_reg <= cfg.enable[2'(scan_index_reg)];
        end
    end

    assign digit_index     = digit_index_reg;
    assign segments_first  = seg_first_reg;
    assign segments_second = seg_second_reg;
    assign enable_lines    = enable_lines_reg;

    `SSMD_ASSERT_NEXT(a_tick_index, clk, rst_n, cmd.tick, digit_index_reg == 2'($past(scan_index_reg)))
    `SSMD_ASSERT_NEXT(a_scan_holds, clk, rst_n, !cmd.tick, $stable(scan_index_reg))
    `SSMD_ASSERT_NEXT(a_clear_fills, clk, rst_n, cmd.clear_all, (first_store_reg[0] == $past(cfg.blank)) && (second_store_reg[DIGITS-1] == $past(cfg.blank)))

endmodule

/* hdl/seven_segment_mux_driver_core.sv */
// Top level of the seven-segment mux driver.
// Instantiates ssmd_cfg_regs, ssmd_ctrl and ssmd_datapath; uses ssmd_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   op selects scan tick, write character, clear dot bits or clear both
//   displays; which_display, position, character and dots_mask are the
//   operands. Only a tick produces a result transfer on the output channel
//   (out_valid/out_ready): the digit shown, both segment bytes and the
//   enable mask of that digit.
//   Timing: a tick's result is registered and presented in the cycle after
//   the tick is accepted. Write, dots and clear commands update the digit stores
//   at the accepting edge and produce nothing.
//   Throughput: one command per cycle while in_ready is high; the single
//   output register frees itself in the cycle it is taken, so back-to-back
//   ticks stream as long as out_ready stays high.
//   Stall: while a result waits and out_ready is low, in_ready drops and the
//   result register holds.
//   Reset: both stores fill with 0xFF, the scan index returns to digit zero,
//   enable masks reset to one-hot 1/2/4/8, no result pending.
//   APB registers (byte address 4*i): blank pattern, then enable masks for
//   digits zero to three; write only while the block is idle.
module seven_segment_mux_driver_core
#(
    parameter int DIGITS = ssmd_pkg::DIGITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssmd_pkg::APB_AW-1:0]  paddr,
    input  logic [ssmd_pkg::APB_DW-1:0]  pwdata,
    output logic [ssmd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // command input
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic                         which_display,
    input  logic [1:0]                   position,
    input  logic [7:0]                   character,
    input  logic [7:0]                   dots_mask,
    // scan result output
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   digit_index,
    output logic [ssmd_pkg::SEG_W-1:0]   segments_first,
    output logic [ssmd_pkg::SEG_W-1:0]   segments_second,
    output logic [ssmd_pkg::SEG_W-1:0]   enable_lines
);

    ssmd_pkg::cfg_t cfg;   // live register values
    ssmd_pkg::cmd_t cmd;   // one-cycle commands from the controller

    ssmd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller owns the handshake; the datapath only sees commands
    ssmd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ssmd_datapath #(
        .DIGITS (DIGITS)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg),
        .which_display   (which_display),
        .position        (position),
        .character       (character),
        .dots_mask       (dots_mask),
        .digit_index     (digit_index),
        .segments_first  (segments_first),
        .segments_second (segments_second),
        .enable_lines    (enable_lines)
    );

endmodule
